/* hw/rtl/call_stack_function_profiler_core_macros.svh */
// assertion helpers for the profiler datapath
`ifndef CALL_STACK_FUNCTION_PROFILER_CORE_MACROS_SVH
`define CALL_STACK_FUNCTION_PROFILER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CSPF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cspf check failed");

// consequent checked in the cycle after the antecedent
`define CSPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cspf check failed");

`endif

/* hw/rtl/cspf_pkg.sv */
package cspf_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_FUNCS   = 64;
  localparam int unsigned DEF_MAX_DEPTH   = 64;
  localparam int unsigned DEF_MAX_CALLEES = 16;

  // register and compare widths
  localparam int unsigned CFG_W = 7;
  localparam int unsigned CAP_W = 11;
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 224;

  // register indexes
  localparam logic CFG_MAX_FUNCS = 1'b0;
  localparam logic CFG_MAX_DEPTH = 1'b1;

  // event codes
  localparam logic [2:0] FUNC_ENTER  = 3'd0;
  localparam logic [2:0] FUNC_LEAVE  = 3'd1;
  localparam logic [2:0] FUNC_PAUSE  = 3'd2;
  localparam logic [2:0] FUNC_RESUME = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TBL_FULL  = 3'd1;
  localparam logic [2:0] ST_STK_FULL  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NO_DATA   = 3'd4;

  typedef struct packed {
    logic [23:0] line;
    logic [31:0] file;
    logic [31:0] name;
  } key_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [31:0] start;
    logic [31:0] child;
    logic [47:0] itot;
    logic [31:0] imin;
    logic [31:0] imax;
    logic [47:0] etot;
    logic [31:0] emin;
    logic [31:0] emax;
  } stat_rec_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic        edge_added;
    logic [5:0]  caller_index;
    logic [31:0] longest_time;
    logic [31:0] shortest_time;
    logic [31:0] average_time;
    logic [47:0] total_time;
    logic [31:0] this_time;
    logic [31:0] call_count;
    logic [5:0]  entry_index;
    logic [2:0]  status;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SCAN_START, OP_KEY_CMP, OP_SYS, OP_ALLOC, OP_CALLER_LD,
    OP_CNT_LD, OP_CEE_CMP, OP_CEE_ADD, OP_PUSH, OP_ENT_WR, OP_POP, OP_LV_EL,
    OP_LV_EX, OP_LV_CALC, OP_LV_WR, OP_PAR_LD, OP_PAR_WR, OP_DIV_START,
    OP_DIV_STEP, OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    FORM_BARE, FORM_ERR2, FORM_ENTER, FORM_STAT
  } form_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DEC, S_KRD, S_KCMP, S_FOUND, S_ALLOC, S_CRD, S_CLD, S_CNT, S_CNTLD,
    S_CEERD, S_CEECMP, S_CADD, S_PUSH, S_ERD, S_EWR, S_EMIT, S_POP, S_LRD, S_LEL,
    S_LEX, S_LCALC, S_LWR, S_PRD, S_PLD, S_PSRD, S_PWR, S_DIVI, S_DIVWI, S_EMITI,
    S_DIVE, S_DIVWE, S_EMITE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    form_e      form;
    logic [2:0] code;
    logic       kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       level_zero;
    logic       hit;
    logic       tbl_full;
    logic       stk_full;
    logic       scan_end;
    logic       key_match;
    logic       cee_end;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/cspf_ram.sv */
module cspf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cspf_dp.sv */
module cspf_dp #(
  parameter int unsigned MAX_FUNCS   = cspf_pkg::DEF_MAX_FUNCS,
  parameter int unsigned MAX_DEPTH   = cspf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned MAX_CALLEES = cspf_pkg::DEF_MAX_CALLEES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [cspf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [cspf_pkg::IN_DATA_W-1:0]  in_tdata_i,
  input  logic [2:0]                      in_tuser_i,
  input  cspf_pkg::cmd_t                  cmd_i,
  output cspf_pkg::sts_t                  sts_o,
  input  logic                            out_tready_i,
  output logic                            out_tvalid_o,
  output logic [cspf_pkg::OUT_DATA_W-1:0] out_tdata_o,
  output logic                            out_tuser_o,
  output logic                            out_tlast_o
);

  localparam int unsigned SW  = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
  localparam int unsigned CW  = $clog2(MAX_FUNCS + 1);
  localparam int unsigned DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CCW = $clog2(MAX_CALLEES + 1);
  localparam int unsigned CD  = MAX_FUNCS * MAX_CALLEES;
  localparam int unsigned CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int unsigned KW  = $bits(cspf_pkg::key_t);
  localparam int unsigned RW  = $bits(cspf_pkg::stat_rec_t);

  // control state
  logic [cspf_pkg::CFG_W-1:0] cfg_funcs_q, cfg_depth_q;
  logic [CW-1:0]  used_q;
  logic [LW-1:0]  level_q;
  logic [31:0]    pause_q, paused_q;
  logic           out_valid_q;

  // working registers
  logic [2:0]          func_q;
  cspf_pkg::key_t      key_q;
  logic [31:0]         ts_q, now_q;
  logic [CW-1:0]       scan_q;
  logic                hit_q, new_q, has_caller_q, use_par_q, dup_q, edge_q;
  logic [SW-1:0]       slot_q, caller_q, par_q;
  logic [CCW-1:0]      cscan_q, ccnt_q;
  logic [31:0]         res_calls_q, el_q, ex_q;
  cspf_pkg::stat_rec_t rec_q;
  logic [47:0]         div_num_q;
  logic [31:0]         div_rem_q;
  logic [5:0]          div_cnt_q;
  cspf_pkg::out_word_t out_word_q;
  logic                out_kind_q, out_last_q;

  // memory ports
  cspf_pkg::key_t      key_rdata;
  cspf_pkg::stat_rec_t st_rdata, st_wdata, ent_rec, lv_rec, par_rec;
  logic                st_we;
  logic [SW-1:0]       st_raddr, st_waddr, stk_rdata, cee_rdata;
  logic [CCW-1:0]      cnt_rdata, cnt_wdata;
  logic                cnt_we, cee_we, add_ok;
  logic [SW-1:0]       cnt_waddr;
  logic [CAW-1:0]      cee_base;

  logic [CCW-1:0]      cnt_capped;
  logic [cspf_pkg::CAP_W-1:0] fcap, dcap;
  logic [32:0]         div_try, child_sum;
  logic [48:0]         isum, esum;
  logic                qbit;
  cspf_pkg::out_word_t emit_word;
  logic [31:0]         avg;

  cspf_ram #(.WIDTH(KW), .DEPTH(MAX_FUNCS)) u_key_ram (
    .clk_i, .we_i(cmd_i.op == cspf_pkg::OP_ALLOC), .waddr_i(SW'(used_q)),
    .wdata_i(key_q), .raddr_i(SW'(scan_q)), .rdata_o(key_rdata)
  );

  cspf_ram #(.WIDTH(RW), .DEPTH(MAX_FUNCS)) u_stat_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  cspf_ram #(.WIDTH(SW), .DEPTH(MAX_DEPTH)) u_stack_ram (
    .clk_i, .we_i(cmd_i.op == cspf_pkg::OP_PUSH), .waddr_i(DW'(level_q)),
    .wdata_i(slot_q), .raddr_i(DW'(level_q - 1'b1)), .rdata_o(stk_rdata)
  );

  cspf_ram #(.WIDTH(CCW), .DEPTH(MAX_FUNCS)) u_count_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(caller_q), .rdata_o(cnt_rdata)
  );

  cspf_ram #(.WIDTH(SW), .DEPTH(CD)) u_callee_ram (
    .clk_i, .we_i(cee_we), .waddr_i(cee_base + CAW'(ccnt_q)), .wdata_i(slot_q),
    .raddr_i(cee_base + CAW'(cscan_q)), .rdata_o(cee_rdata)
  );

  // address and write selection
  assign cee_base   = CAW'(caller_q) * CAW'(MAX_CALLEES);
  assign add_ok     = !dup_q && (ccnt_q < CCW'(MAX_CALLEES));
  assign cee_we     = (cmd_i.op == cspf_pkg::OP_CEE_ADD) && add_ok;
  assign cnt_we     = (cmd_i.op == cspf_pkg::OP_ALLOC) || cee_we;
  assign cnt_waddr  = (cmd_i.op == cspf_pkg::OP_ALLOC) ? SW'(used_q) : caller_q;
  assign cnt_wdata  = (cmd_i.op == cspf_pkg::OP_ALLOC) ? '0 : ccnt_q + 1'b1;
  assign cnt_capped = (cnt_rdata > CCW'(MAX_CALLEES)) ? CCW'(MAX_CALLEES) : cnt_rdata;
  assign st_raddr   = use_par_q ? par_q : slot_q;
  assign st_waddr   = (cmd_i.op == cspf_pkg::OP_PAR_WR) ? par_q : slot_q;

  always_comb begin
    st_we    = 1'b1;
    st_wdata = rec_q;
    case (cmd_i.op)
      cspf_pkg::OP_ENT_WR: st_wdata = ent_rec;
      cspf_pkg::OP_LV_WR:  st_wdata = rec_q;
      cspf_pkg::OP_PAR_WR: st_wdata = par_rec;
      default:             st_we = 1'b0;
    endcase
  end

  // record on enter: fresh slot starts from zero
  always_comb begin
    ent_rec       = new_q ? '0 : st_rdata;
    ent_rec.calls = (ent_rec.calls == 32'hFFFF_FFFF) ? ent_rec.calls
                                                     : ent_rec.calls + 32'd1;
    ent_rec.start = now_q;
    ent_rec.child = '0;
  end

  // record on leave: restart on first call, else min, max and saturating total
  assign isum = {1'b0, st_rdata.itot} + 49'(el_q);
  assign esum = {1'b0, st_rdata.etot} + 49'(ex_q);

  always_comb begin
    lv_rec = st_rdata;
    if (st_rdata.calls == 32'd1) begin
      lv_rec.itot = 48'(el_q);
      lv_rec.imin = el_q;
      lv_rec.imax = el_q;
      lv_rec.etot = 48'(ex_q);
      lv_rec.emin = ex_q;
      lv_rec.emax = ex_q;
    end else begin
      if (el_q < st_rdata.imin) lv_rec.imin = el_q;
      if (el_q > st_rdata.imax) lv_rec.imax = el_q;
      lv_rec.itot = isum[48] ? '1 : isum[47:0];
      if (ex_q < st_rdata.emin) lv_rec.emin = ex_q;
      if (ex_q > st_rdata.emax) lv_rec.emax = ex_q;
      lv_rec.etot = esum[48] ? '1 : esum[47:0];
    end
  end

  // caller takes the exclusive time of its callee
  assign child_sum = {1'b0, st_rdata.child} + {1'b0, ex_q};
  always_comb begin
    par_rec       = st_rdata;
    par_rec.child = child_sum[32] ? '1 : child_sum[31:0];
  end

  // one restoring division step
  assign div_try = {div_rem_q, div_num_q[47]};
  assign qbit    = div_try >= {1'b0, rec_q.calls};
  assign avg     = (rec_q.calls == '0) ? '0 : ((|div_num_q[47:32]) ? '1 : div_num_q[31:0]);

  // result word
  always_comb begin
    emit_word        = '0;
    emit_word.status = cmd_i.code;
    case (cmd_i.form)
      cspf_pkg::FORM_ERR2: emit_word.entry_index = 6'(slot_q);
      cspf_pkg::FORM_ENTER: begin
        emit_word.entry_index  = 6'(slot_q);
        emit_word.call_count   = res_calls_q;
        emit_word.caller_index = has_caller_q ? 6'(caller_q) : '0;
        emit_word.edge_added   = edge_q;
      end
      cspf_pkg::FORM_STAT: begin
        emit_word.entry_index   = 6'(slot_q);
        emit_word.call_count    = rec_q.calls;
        emit_word.this_time     = cmd_i.kind ? ex_q : el_q;
        emit_word.total_time    = cmd_i.kind ? rec_q.etot : rec_q.itot;
        emit_word.average_time  = avg;
        emit_word.shortest_time = cmd_i.kind ? rec_q.emin : rec_q.imin;
        emit_word.longest_time  = cmd_i.kind ? rec_q.emax : rec_q.imax;
      end
      default: emit_word.entry_index = '0;
    endcase
  end

  // limits from the registers, capped at the sizes
  assign fcap = (cspf_pkg::CAP_W'(cfg_funcs_q) > cspf_pkg::CAP_W'(MAX_FUNCS))
              ? cspf_pkg::CAP_W'(MAX_FUNCS) : cspf_pkg::CAP_W'(cfg_funcs_q);
  assign dcap = (cspf_pkg::CAP_W'(cfg_depth_q) > cspf_pkg::CAP_W'(MAX_DEPTH))
              ? cspf_pkg::CAP_W'(MAX_DEPTH) : cspf_pkg::CAP_W'(cfg_depth_q);

  // status towards the controller
  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.level_zero = (level_q == '0);
    sts_o.hit        = hit_q;
    sts_o.tbl_full   = !hit_q && (cspf_pkg::CAP_W'(used_q) >= fcap);
    sts_o.stk_full   = cspf_pkg::CAP_W'(level_q) >= dcap;
    sts_o.scan_end   = scan_q >= used_q;
    sts_o.key_match  = (key_rdata == key_q);
    sts_o.cee_end    = cscan_q >= ccnt_q;
    sts_o.div_done   = (div_cnt_q == '0);
    sts_o.out_free   = !out_valid_q || out_tready_i;
  end

  // registers, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_funcs_q <= cspf_pkg::CFG_W'(cspf_pkg::DEF_MAX_FUNCS);
      cfg_depth_q <= cspf_pkg::CFG_W'(cspf_pkg::DEF_MAX_DEPTH);
      used_q      <= '0;
      level_q     <= '0;
      pause_q     <= '0;
      paused_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cspf_pkg::CFG_MAX_FUNCS: cfg_funcs_q <= cfg_data_i;
          default:                 cfg_depth_q <= cfg_data_i;
        endcase
      end
      case (cmd_i.op)
        cspf_pkg::OP_ALLOC: used_q  <= used_q + 1'b1;
        cspf_pkg::OP_PUSH:  level_q <= level_q + 1'b1;
        cspf_pkg::OP_POP:   level_q <= level_q - 1'b1;
        cspf_pkg::OP_SYS: begin
          case (func_q)
            cspf_pkg::FUNC_PAUSE:  pause_q  <= ts_q;
            cspf_pkg::FUNC_RESUME: paused_q <= paused_q + (ts_q - pause_q);
            cspf_pkg::FUNC_CLEAR: begin
              used_q   <= '0;
              level_q  <= '0;
              pause_q  <= '0;
              paused_q <= '0;
            end
            default: pause_q <= pause_q;
          endcase
        end
        default: used_q <= used_q;
      endcase
      if (cmd_i.op == cspf_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cspf_pkg::OP_LOAD: begin
        func_q       <= in_tuser_i;
        key_q        <= in_tdata_i[KW-1:0];
        ts_q         <= in_tdata_i[119:88];
        now_q        <= in_tdata_i[119:88] - paused_q;
        has_caller_q <= 1'b0;
        edge_q       <= 1'b0;
        use_par_q    <= 1'b0;
        new_q        <= 1'b0;
      end
      cspf_pkg::OP_SCAN_START: begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        slot_q <= '0;
      end
      cspf_pkg::OP_KEY_CMP: begin
        if (key_rdata == key_q) begin
          hit_q  <= 1'b1;
          slot_q <= SW'(scan_q);
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      cspf_pkg::OP_ALLOC: begin
        slot_q <= SW'(used_q);
        new_q  <= 1'b1;
      end
      cspf_pkg::OP_CALLER_LD: begin
        caller_q     <= stk_rdata;
        has_caller_q <= 1'b1;
      end
      cspf_pkg::OP_CNT_LD: begin
        ccnt_q  <= cnt_capped;
        cscan_q <= '0;
        dup_q   <= 1'b0;
      end
      cspf_pkg::OP_CEE_CMP: begin
        if (cee_rdata == slot_q) dup_q <= 1'b1;
        cscan_q <= cscan_q + 1'b1;
      end
      cspf_pkg::OP_CEE_ADD: edge_q      <= add_ok;
      cspf_pkg::OP_ENT_WR:  res_calls_q <= ent_rec.calls;
      cspf_pkg::OP_LV_EL:   el_q        <= now_q - st_rdata.start;
      cspf_pkg::OP_LV_EX:   ex_q        <= (el_q > st_rdata.child) ? el_q - st_rdata.child : '0;
      cspf_pkg::OP_LV_CALC: rec_q       <= lv_rec;
      cspf_pkg::OP_PAR_LD: begin
        par_q     <= stk_rdata;
        use_par_q <= 1'b1;
      end
      cspf_pkg::OP_DIV_START: begin
        div_num_q <= cmd_i.kind ? rec_q.etot : rec_q.itot;
        div_rem_q <= '0;
        div_cnt_q <= 6'd48;
      end
      cspf_pkg::OP_DIV_STEP: begin
        div_rem_q <= qbit ? 32'(div_try - {1'b0, rec_q.calls}) : div_try[31:0];
        div_num_q <= {div_num_q[46:0], qbit};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      cspf_pkg::OP_EMIT: begin
        out_word_q <= emit_word;
        out_kind_q <= cmd_i.kind;
        out_last_q <= cmd_i.last;
      end
      default: func_q <= func_q;
    endcase
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_word_q;
  assign out_tuser_o  = out_kind_q;
  assign out_tlast_o  = out_last_q;

`include "call_stack_function_profiler_core_macros.svh"

  `CSPF_ASSERT(a_emit_slot_free, (cmd_i.op == cspf_pkg::OP_EMIT) |-> (!out_valid_q || out_tready_i))
  `CSPF_ASSERT(a_alloc_room, (cmd_i.op == cspf_pkg::OP_ALLOC) |-> (used_q < CW'(MAX_FUNCS)))
  `CSPF_ASSERT_NEXT(a_push_grows, cmd_i.op == cspf_pkg::OP_PUSH, level_q == LW'($past(level_q) + 1'b1))

endmodule

/* hw/rtl/cspf_ctrl.sv */
module cspf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_tvalid_i,
  output logic           in_tready_o,
  input  cspf_pkg::sts_t sts_i,
  output cspf_pkg::cmd_t cmd_o
);

  cspf_pkg::ctrl_state_e state_q, state_d;
  logic [2:0]            code_q, code_d;
  cspf_pkg::form_e       form_q, form_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cspf_pkg::S_IDLE;
      code_q  <= cspf_pkg::ST_OK;
      form_q  <= cspf_pkg::FORM_BARE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      form_q  <= form_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    form_d  = form_q;
    case (state_q)
      cspf_pkg::S_IDLE: if (in_tvalid_i) state_d = cspf_pkg::S_DEC;
      cspf_pkg::S_DEC: begin
        state_d = cspf_pkg::S_EMIT;
        code_d  = cspf_pkg::ST_OK;
        form_d  = cspf_pkg::FORM_BARE;
        case (sts_i.func)
          cspf_pkg::FUNC_ENTER: state_d = cspf_pkg::S_KRD;
          cspf_pkg::FUNC_LEAVE: begin
            if (sts_i.level_zero) code_d = cspf_pkg::ST_NOT_FOUND;
            else state_d = cspf_pkg::S_KRD;
          end
          cspf_pkg::FUNC_PAUSE, cspf_pkg::FUNC_RESUME, cspf_pkg::FUNC_CLEAR:
            code_d = cspf_pkg::ST_OK;
          default: code_d = cspf_pkg::ST_NO_DATA;
        endcase
      end
      cspf_pkg::S_KRD:
        state_d = sts_i.scan_end ? cspf_pkg::S_FOUND : cspf_pkg::S_KCMP;
      cspf_pkg::S_KCMP:
        state_d = sts_i.key_match ? cspf_pkg::S_FOUND : cspf_pkg::S_KRD;
      cspf_pkg::S_FOUND: begin
        form_d = cspf_pkg::FORM_BARE;
        if (sts_i.func == cspf_pkg::FUNC_LEAVE) begin
          if (!sts_i.hit) begin
            state_d = cspf_pkg::S_EMIT;
            code_d  = cspf_pkg::ST_NOT_FOUND;
          end else begin
            state_d = cspf_pkg::S_POP;
          end
        end else if (sts_i.tbl_full) begin
          state_d = cspf_pkg::S_EMIT;
          code_d  = cspf_pkg::ST_TBL_FULL;
        end else if (sts_i.stk_full) begin
          state_d = cspf_pkg::S_EMIT;
          code_d  = cspf_pkg::ST_STK_FULL;
          form_d  = cspf_pkg::FORM_ERR2;
        end else if (!sts_i.hit) begin
          state_d = cspf_pkg::S_ALLOC;
        end else begin
          state_d = sts_i.level_zero ? cspf_pkg::S_PUSH : cspf_pkg::S_CRD;
        end
      end
      cspf_pkg::S_ALLOC:
        state_d = sts_i.level_zero ? cspf_pkg::S_PUSH : cspf_pkg::S_CRD;
      cspf_pkg::S_CRD:   state_d = cspf_pkg::S_CLD;
      cspf_pkg::S_CLD:   state_d = cspf_pkg::S_CNT;
      cspf_pkg::S_CNT:   state_d = cspf_pkg::S_CNTLD;
      cspf_pkg::S_CNTLD: state_d = cspf_pkg::S_CEERD;
      cspf_pkg::S_CEERD:
        state_d = sts_i.cee_end ? cspf_pkg::S_CADD : cspf_pkg::S_CEECMP;
      cspf_pkg::S_CEECMP: state_d = cspf_pkg::S_CEERD;
      cspf_pkg::S_CADD:   state_d = cspf_pkg::S_PUSH;
      cspf_pkg::S_PUSH:   state_d = cspf_pkg::S_ERD;
      cspf_pkg::S_ERD:    state_d = cspf_pkg::S_EWR;
      cspf_pkg::S_EWR: begin
        state_d = cspf_pkg::S_EMIT;
        code_d  = cspf_pkg::ST_OK;
        form_d  = cspf_pkg::FORM_ENTER;
      end
      cspf_pkg::S_EMIT: if (sts_i.out_free) state_d = cspf_pkg::S_IDLE;
      cspf_pkg::S_POP:   state_d = cspf_pkg::S_LRD;
      cspf_pkg::S_LRD:   state_d = cspf_pkg::S_LEL;
      cspf_pkg::S_LEL:   state_d = cspf_pkg::S_LEX;
      cspf_pkg::S_LEX:   state_d = cspf_pkg::S_LCALC;
      cspf_pkg::S_LCALC: state_d = cspf_pkg::S_LWR;
      cspf_pkg::S_LWR:
        state_d = sts_i.level_zero ? cspf_pkg::S_DIVI : cspf_pkg::S_PRD;
      cspf_pkg::S_PRD:  state_d = cspf_pkg::S_PLD;
      cspf_pkg::S_PLD:  state_d = cspf_pkg::S_PSRD;
      cspf_pkg::S_PSRD: state_d = cspf_pkg::S_PWR;
      cspf_pkg::S_PWR:  state_d = cspf_pkg::S_DIVI;
      cspf_pkg::S_DIVI: state_d = cspf_pkg::S_DIVWI;
      cspf_pkg::S_DIVWI: if (sts_i.div_done) state_d = cspf_pkg::S_EMITI;
      cspf_pkg::S_EMITI: if (sts_i.out_free) state_d = cspf_pkg::S_DIVE;
      cspf_pkg::S_DIVE: state_d = cspf_pkg::S_DIVWE;
      cspf_pkg::S_DIVWE: if (sts_i.div_done) state_d = cspf_pkg::S_EMITE;
      cspf_pkg::S_EMITE: if (sts_i.out_free) state_d = cspf_pkg::S_IDLE;
      default: state_d = cspf_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_tready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = cspf_pkg::OP_NONE;
    cmd_o.form  = cspf_pkg::FORM_BARE;
    cmd_o.code  = cspf_pkg::ST_OK;
    case (state_q)
      cspf_pkg::S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) cmd_o.op = cspf_pkg::OP_LOAD;
      end
      cspf_pkg::S_DEC: begin
        case (sts_i.func)
          cspf_pkg::FUNC_ENTER, cspf_pkg::FUNC_LEAVE: cmd_o.op = cspf_pkg::OP_SCAN_START;
          cspf_pkg::FUNC_PAUSE, cspf_pkg::FUNC_RESUME, cspf_pkg::FUNC_CLEAR:
            cmd_o.op = cspf_pkg::OP_SYS;
          default: cmd_o.op = cspf_pkg::OP_NONE;
        endcase
      end
      cspf_pkg::S_KCMP:   cmd_o.op = cspf_pkg::OP_KEY_CMP;
      cspf_pkg::S_ALLOC:  cmd_o.op = cspf_pkg::OP_ALLOC;
      cspf_pkg::S_CLD:    cmd_o.op = cspf_pkg::OP_CALLER_LD;
      cspf_pkg::S_CNTLD:  cmd_o.op = cspf_pkg::OP_CNT_LD;
      cspf_pkg::S_CEECMP: cmd_o.op = cspf_pkg::OP_CEE_CMP;
      cspf_pkg::S_CADD:   cmd_o.op = cspf_pkg::OP_CEE_ADD;
      cspf_pkg::S_PUSH:   cmd_o.op = cspf_pkg::OP_PUSH;
      cspf_pkg::S_EWR:    cmd_o.op = cspf_pkg::OP_ENT_WR;
      cspf_pkg::S_EMIT: begin
        if (sts_i.out_free) cmd_o.op = cspf_pkg::OP_EMIT;
        cmd_o.code = code_q;
        cmd_o.form = form_q;
        cmd_o.last = 1'b1;
      end
      cspf_pkg::S_POP:   cmd_o.op = cspf_pkg::OP_POP;
      cspf_pkg::S_LEL:   cmd_o.op = cspf_pkg::OP_LV_EL;
      cspf_pkg::S_LEX:   cmd_o.op = cspf_pkg::OP_LV_EX;
      cspf_pkg::S_LCALC: cmd_o.op = cspf_pkg::OP_LV_CALC;
      cspf_pkg::S_LWR:   cmd_o.op = cspf_pkg::OP_LV_WR;
      cspf_pkg::S_PLD:   cmd_o.op = cspf_pkg::OP_PAR_LD;
      cspf_pkg::S_PWR:   cmd_o.op = cspf_pkg::OP_PAR_WR;
      cspf_pkg::S_DIVI:  cmd_o.op = cspf_pkg::OP_DIV_START;
      cspf_pkg::S_DIVWI, cspf_pkg::S_DIVWE:
        if (!sts_i.div_done) cmd_o.op = cspf_pkg::OP_DIV_STEP;
      cspf_pkg::S_EMITI: begin
        if (sts_i.out_free) cmd_o.op = cspf_pkg::OP_EMIT;
        cmd_o.form = cspf_pkg::FORM_STAT;
      end
      cspf_pkg::S_DIVE: begin
        cmd_o.op   = cspf_pkg::OP_DIV_START;
        cmd_o.kind = 1'b1;
      end
      cspf_pkg::S_EMITE: begin
        if (sts_i.out_free) cmd_o.op = cspf_pkg::OP_EMIT;
        cmd_o.form = cspf_pkg::FORM_STAT;
        cmd_o.kind = 1'b1;
        cmd_o.last = 1'b1;
      end
      default: cmd_o.op = cspf_pkg::OP_NONE;
    endcase
  end

endmodule

/* hw/rtl/call_stack_function_profiler_core.sv */
// enter: k slots searched for the key, then the callee entries of the caller scanned
// leave: ends in two bit-serial divisions of the 48-bit totals for the averages
// one event at a time; pause, resume and clear go from decode straight to the result
// a finished result waits in the output register while the next event is taken
// reset: asynchronous, active low; empties table and stack, registers back to 64
module call_stack_function_profiler_core #(
  parameter int unsigned MAX_FUNCS   = cspf_pkg::DEF_MAX_FUNCS,
  parameter int unsigned MAX_DEPTH   = cspf_pkg::DEF_MAX_DEPTH,
  parameter int unsigned MAX_CALLEES = cspf_pkg::DEF_MAX_CALLEES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [cspf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // name_hash, file_hash, line, timestamp
  input  logic [cspf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, entry_index, call_count, this_time, total_time, average_time,
  // shortest_time, longest_time, caller_index, edge_added
  output logic [cspf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // stat_kind
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  cspf_pkg::cmd_t cmd;
  cspf_pkg::sts_t sts;

  cspf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_tvalid_i(s_axis_tvalid), .in_tready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  cspf_dp #(
    .MAX_FUNCS(MAX_FUNCS), .MAX_DEPTH(MAX_DEPTH), .MAX_CALLEES(MAX_CALLEES)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_tdata_i(s_axis_tdata), .in_tuser_i(s_axis_tuser),
    .cmd_i(cmd), .sts_o(sts),
    .out_tready_i(m_axis_tready), .out_tvalid_o(m_axis_tvalid),
    .out_tdata_o(m_axis_tdata), .out_tuser_o(m_axis_tuser), .out_tlast_o(m_axis_tlast)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cspf_pkg::*;

  localparam int unsigned NFN  = 64;
  localparam int unsigned NDP  = 64;
  localparam int unsigned NCEE = 16;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned RAND_ITEMS = 360;
  localparam int unsigned POOL_N = 20;
  // codes above clear carry no operation
  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;
  localparam logic KIND_INCL = 1'b0;
  localparam logic KIND_EXCL = 1'b1;

  typedef struct {
    out_word_t w;
    logic      kind;
    logic      last;
  } profile_res_t;

  typedef struct packed {
    logic [31:0] name;
    logic [31:0] file;
    logic [23:0] line;
  } fn_key_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  call_stack_function_profiler_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // profiler shadow state
  logic [6:0]  lim_funcs, lim_depth;
  fn_key_t     tbl_key [NFN];
  logic [31:0] tbl_calls [NFN], tbl_start [NFN], tbl_child [NFN];
  logic [47:0] tbl_itot [NFN], tbl_etot [NFN];
  logic [31:0] tbl_imin [NFN], tbl_imax [NFN], tbl_emin [NFN], tbl_emax [NFN];
  logic [5:0]  cee_list [NFN][NCEE];
  int unsigned cee_cnt [NFN];
  logic [5:0]  call_stk [NDP];
  int unsigned fn_used, stk_lvl;
  logic [31:0] pause_at, paused_sum;

  profile_res_t pending_res[$];
  int unsigned  n_fail = 0;
  bit           idle_on = 1'b1;
  logic [31:0]  tick_now = 32'd1000;
  fn_key_t      key_pool [POOL_N];

  function automatic int unsigned cap_of(int unsigned v, int unsigned m);
    return (v > m) ? m : v;
  endfunction

  function automatic int find_fn(fn_key_t k);
    int unsigned n;
    n = cap_of(fn_used, NFN);
    for (int unsigned i = 0; i < n; i++)
      if (tbl_key[i] == k) return int'(i);
    return -1;
  endfunction

  function automatic void push_res(logic [2:0] st, logic [5:0] idx, logic kind, logic last,
                                   logic [31:0] n, logic [31:0] t, logic [47:0] tot,
                                   logic [31:0] mn, logic [31:0] mx);
    profile_res_t r;
    logic [63:0] avg;
    avg = (n != 0) ? {16'd0, tot} / {32'd0, n} : 64'd0;
    r.w = '0;
    r.w.status = st;
    r.w.entry_index = idx;
    r.w.call_count = n;
    r.w.this_time = t;
    r.w.total_time = tot;
    r.w.average_time = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
    r.w.shortest_time = mn;
    r.w.longest_time = mx;
    r.kind = kind;
    r.last = last;
    pending_res.push_back(r);
  endfunction

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // works out the results of one event and advances the shadow state
  function automatic void profile_event(logic [2:0] func, fn_key_t k, logic [31:0] ts);
    int s;
    int unsigned idx, fcap, dcap, cnt, caller, par;
    logic [31:0] now, el, ex;
    logic [32:0] csum;
    bit dup, edge_new;
    profile_res_t r;
    fcap = cap_of(lim_funcs, NFN);
    dcap = cap_of(lim_depth, NDP);
    now = ts - paused_sum;
    case (func)
      FUNC_ENTER: begin
        s = find_fn(k);
        if (s < 0 && fn_used >= fcap) begin
          push_res(ST_TBL_FULL, 0, KIND_INCL, 1, 0, 0, 0, 0, 0);
          return;
        end
        if (stk_lvl >= dcap) begin
          push_res(ST_STK_FULL, (s < 0) ? 6'd0 : s[5:0], KIND_INCL, 1, 0, 0, 0, 0, 0);
          return;
        end
        if (s < 0) begin
          idx = fn_used++;
          tbl_key[idx] = k;
          tbl_calls[idx] = 0; cee_cnt[idx] = 0;
          tbl_itot[idx] = 0; tbl_imin[idx] = 0; tbl_imax[idx] = 0;
          tbl_etot[idx] = 0; tbl_emin[idx] = 0; tbl_emax[idx] = 0;
        end else begin
          idx = s;
        end
        caller = 0;
        edge_new = 1'b0;
        if (stk_lvl >= 1) begin
          caller = call_stk[stk_lvl-1];
          cnt = cap_of(cee_cnt[caller], NCEE);
          dup = 1'b0;
          for (int unsigned i = 0; i < cnt; i++)
            if (cee_list[caller][i] == 6'(idx)) dup = 1'b1;
          if (!dup && cnt < NCEE) begin
            cee_list[caller][cnt] = 6'(idx);
            cee_cnt[caller] = cnt + 1;
            edge_new = 1'b1;
          end
        end
        call_stk[stk_lvl++] = 6'(idx);
        tbl_start[idx] = now;
        if (tbl_calls[idx] != 32'hFFFF_FFFF) tbl_calls[idx]++;
        tbl_child[idx] = 0;
        r.w = '0;
        r.w.status = ST_OK;
        r.w.entry_index = 6'(idx);
        r.w.call_count = tbl_calls[idx];
        r.w.caller_index = 6'(caller);
        r.w.edge_added = edge_new;
        r.kind = KIND_INCL;
        r.last = 1'b1;
        pending_res.push_back(r);
      end
      FUNC_LEAVE: begin
        s = (stk_lvl == 0) ? -1 : find_fn(k);
        if (s < 0) begin
          push_res(ST_NOT_FOUND, 0, KIND_INCL, 1, 0, 0, 0, 0, 0);
          return;
        end
        idx = s;
        stk_lvl--;
        el = now - tbl_start[idx];
        ex = (el > tbl_child[idx]) ? el - tbl_child[idx] : 32'd0;
        if (tbl_calls[idx] == 1) begin
          tbl_itot[idx] = 48'(el); tbl_imin[idx] = el; tbl_imax[idx] = el;
          tbl_etot[idx] = 48'(ex); tbl_emin[idx] = ex; tbl_emax[idx] = ex;
        end else begin
          if (el < tbl_imin[idx]) tbl_imin[idx] = el;
          if (el > tbl_imax[idx]) tbl_imax[idx] = el;
          tbl_itot[idx] = sat_add48(tbl_itot[idx], el);
          if (ex < tbl_emin[idx]) tbl_emin[idx] = ex;
          if (ex > tbl_emax[idx]) tbl_emax[idx] = ex;
          tbl_etot[idx] = sat_add48(tbl_etot[idx], ex);
        end
        // exclusive time is charged to the caller left on top
        if (stk_lvl >= 1) begin
          par = call_stk[stk_lvl-1];
          csum = {1'b0, tbl_child[par]} + {1'b0, ex};
          tbl_child[par] = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
        end
        push_res(ST_OK, 6'(idx), KIND_INCL, 0, tbl_calls[idx], el, tbl_itot[idx],
                 tbl_imin[idx], tbl_imax[idx]);
        push_res(ST_OK, 6'(idx), KIND_EXCL, 1, tbl_calls[idx], ex, tbl_etot[idx],
                 tbl_emin[idx], tbl_emax[idx]);
      end
      FUNC_PAUSE, FUNC_RESUME, FUNC_CLEAR: begin
        if (func == FUNC_PAUSE) begin
          pause_at = ts;
        end else if (func == FUNC_RESUME) begin
          paused_sum = paused_sum + (ts - pause_at);
        end else begin
          fn_used = 0; stk_lvl = 0; pause_at = 0; paused_sum = 0;
        end
        push_res(ST_OK, 0, KIND_INCL, 1, 0, 0, 0, 0, 0);
      end
      default: push_res(ST_NO_DATA, 0, KIND_INCL, 1, 0, 0, 0, 0, 0);
    endcase
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_event(logic [2:0] func, fn_key_t k, logic [31:0] ts);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    profile_event(func, k, ts);
    s_axis_tuser = func;
    s_axis_tdata = {ts, k.line, k.file, k.name};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic tick_on(int unsigned step);
    tick_now = tick_now + step;
  endtask

  task automatic send_at(logic [2:0] func, fn_key_t k);
    tick_on($urandom_range(1, 3000));
    send_event(func, k, tick_now);
  endtask

  // waits for all results, then lets a late leave settle before a register write
  task automatic wait_idle();
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limits(logic [6:0] nfuncs, logic [6:0] ndepth);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_MAX_FUNCS;
    cfg_data_i = nfuncs;
    @(negedge clk_i);
    cfg_idx_i = CFG_MAX_DEPTH;
    cfg_data_i = ndepth;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    lim_funcs = nfuncs;
    lim_depth = ndepth;
  endtask

  function automatic fn_key_t rand_key();
    fn_key_t k;
    k.name = $urandom();
    k.file = $urandom();
    k.line = 24'($urandom());
    return k;
  endfunction

  // nesting, extreme keys and ticks, pause and resume, unused codes, clear
  task automatic test_basic();
    fn_key_t k_lo, k_hi, k_mid;
    k_lo = '{32'd0, 32'd0, 24'd0};
    k_hi = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF};
    k_mid = rand_key();
    send_at(FUNC_LEAVE, k_lo);
    send_event(FUNC_ENTER, k_lo, 32'hFFFF_FF00);
    send_event(FUNC_ENTER, k_hi, 32'hFFFF_FFF0);
    send_event(FUNC_PAUSE, k_mid, 32'h0000_0010);
    send_event(FUNC_RESUME, k_mid, 32'h0000_0100);
    send_event(FUNC_ENTER, k_hi, 32'h0000_0200);
    send_event(FUNC_LEAVE, k_hi, 32'h0000_0300);
    send_event(FUNC_LEAVE, k_hi, 32'hFFFF_FFFF);
    send_at(FUNC_LEAVE, k_mid);
    send_at(FUNC_ENTER, k_mid);
    send_at(FUNC_LEAVE, k_mid);
    send_at(FUNC_LEAVE, k_lo);
    send_at(FUNC_LEAVE, k_lo);
    for (logic [2:0] c = FUNC_RSVD_FIRST; c <= FUNC_RSVD_LAST && c != 3'd0; c++)
      send_at(c, k_mid);
    send_at(FUNC_CLEAR, k_mid);
    send_at(FUNC_LEAVE, k_mid);
  endtask

  // full table, full stack and the empty settings
  task automatic test_limits();
    write_limits(7'd2, 7'd1);
    send_at(FUNC_ENTER, key_pool[0]);
    send_at(FUNC_ENTER, key_pool[1]);
    send_at(FUNC_ENTER, key_pool[0]);
    send_at(FUNC_LEAVE, key_pool[0]);
    send_at(FUNC_ENTER, key_pool[1]);
    send_at(FUNC_LEAVE, key_pool[1]);
    send_at(FUNC_ENTER, key_pool[2]);
    write_limits(7'd0, 7'd0);
    send_at(FUNC_ENTER, key_pool[0]);
    send_at(FUNC_ENTER, key_pool[3]);
    send_at(FUNC_CLEAR, key_pool[3]);
    write_limits(7'd64, 7'd64);
  endtask

  // a caller that runs out of callee room
  task automatic test_callee_room();
    send_at(FUNC_ENTER, key_pool[0]);
    for (int unsigned i = 1; i <= NCEE + 1; i++) begin
      send_at(FUNC_ENTER, key_pool[i]);
      send_at(FUNC_LEAVE, key_pool[i]);
    end
    send_at(FUNC_ENTER, key_pool[1]);
    send_at(FUNC_LEAVE, key_pool[1]);
    send_at(FUNC_LEAVE, key_pool[0]);
    send_at(FUNC_CLEAR, key_pool[0]);
  endtask

  // mostly well nested call traces with random content
  task automatic test_random_trace(int unsigned n_items, bit quiet_tail);
    int unsigned pick;
    fn_key_t k;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (quiet_tail && i >= n_items - n_items / 5) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (stk_lvl > 10 && pick < 45) pick = pick + 45;
      if ($urandom_range(0, 40) == 0) tick_now = $urandom();
      if (pick < 45 || (stk_lvl == 0 && pick < 85)) begin
        send_at(FUNC_ENTER, key_pool[$urandom_range(0, POOL_N-1)]);
      end else if (pick < 85) begin
        k = tbl_key[call_stk[stk_lvl-1]];
        send_at(FUNC_LEAVE, k);
      end else if (pick < 89) begin
        send_at(FUNC_LEAVE, key_pool[$urandom_range(0, POOL_N-1)]);
      end else if (pick < 91) begin
        send_at(FUNC_LEAVE, rand_key());
      end else if (pick < 96) begin
        send_at(FUNC_PAUSE, rand_key());
        send_at(FUNC_RESUME, rand_key());
      end else if (pick < 98) begin
        send_at(3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST)), rand_key());
      end else begin
        send_at(FUNC_CLEAR, rand_key());
      end
    end
  endtask

  // output side stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_word_t got;
    profile_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_word_t'(m_axis_tdata);
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result: actual %h kind %b last %b",
                 $time, got, m_axis_tuser, m_axis_tlast);
        n_fail++;
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.w.status || got.entry_index !== want.w.entry_index ||
            got.call_count !== want.w.call_count || got.this_time !== want.w.this_time ||
            got.total_time !== want.w.total_time ||
            got.average_time !== want.w.average_time ||
            got.shortest_time !== want.w.shortest_time ||
            got.longest_time !== want.w.longest_time ||
            got.caller_index !== want.w.caller_index ||
            got.edge_added !== want.w.edge_added ||
            m_axis_tuser !== want.kind || m_axis_tlast !== want.last) begin
          $display("%0t result mismatch: expected %h kind %b last %b, actual %h kind %b last %b",
                   $time, want.w, want.kind, want.last, got, m_axis_tuser, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    lim_funcs = 7'd64; lim_depth = 7'd64;
    fn_used = 0; stk_lvl = 0; pause_at = 0; paused_sum = 0;
    for (int unsigned i = 0; i < POOL_N; i++) key_pool[i] = rand_key();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_basic();
    test_limits();
    test_callee_room();
    test_random_trace(RAND_ITEMS / 3, 1'b0);
    write_limits(7'd12, 7'd6);
    test_random_trace(RAND_ITEMS / 3, 1'b0);
    write_limits(7'd64, 7'd64);
    for (int unsigned i = 0; i < POOL_N; i++) key_pool[i] = rand_key();
    test_random_trace(RAND_ITEMS / 3, 1'b1);
    idle_on = 1'b0;
    wait_idle();
    if (n_fail == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
